// ===== rtl/plct_pkg.sv =====
// Shared types and constants for the piecewise-linear calibration table.
package plct_pkg;

  localparam int CODE_W = 24;
  localparam int VAL_W  = 32;
  localparam int CAP_W  = 5;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
  localparam logic [OP_W-1:0] OP_RSVD   = 2'd3;  // unused, no state change

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FEW  = 2'd2;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Command broadcast to every cell
  typedef struct packed {
    logic                     ins;   // insert key/value in order
    logic                     upd;   // replace value on matching code
    logic signed [CODE_W-1:0] key;
    logic signed [VAL_W-1:0]  value;
  } cell_cmd_t;

  // Where a cell stands relative to the fill count
  typedef struct packed {
    logic occ;     // cell holds a valid point
    logic at_end;  // cell is the first free slot
  } cell_pos_t;

endpackage

// ===== rtl/plct_if.sv =====
// Valid/ready channel interfaces for input and result items.
interface plct_in_if;
  logic                               valid;
  logic                               ready;
  logic [plct_pkg::OP_W-1:0]          op;
  logic signed [plct_pkg::CODE_W-1:0] code;
  logic signed [plct_pkg::VAL_W-1:0]  point_value;

  modport source (output valid, op, code, point_value, input ready);
  modport sink   (input valid, op, code, point_value, output ready);
endinterface

interface plct_out_if;
  logic                              valid;
  logic                              ready;
  logic [plct_pkg::STAT_W-1:0]       status;
  logic signed [plct_pkg::VAL_W-1:0] result_value;

  modport source (output valid, status, result_value, input ready);
  modport sink   (input valid, status, result_value, output ready);
endinterface

// ===== rtl/plct_cell.sv =====
// One table cell: holds a point, compares it with the key, shifts on insert.
module plct_cell (
  input  logic                               clk_i,
  input  plct_pkg::cell_cmd_t                cmd_i,
  input  plct_pkg::cell_pos_t                pos_i,
  input  logic signed [plct_pkg::CODE_W-1:0] left_code_i,
  input  logic signed [plct_pkg::VAL_W-1:0]  left_val_i,
  input  logic                               left_gt_i,
  output logic signed [plct_pkg::CODE_W-1:0] code_o,
  output logic signed [plct_pkg::VAL_W-1:0]  val_o,
  output logic                               gt_o,
  output logic                               eq_o
);

  logic signed [plct_pkg::CODE_W-1:0] code_q;
  logic signed [plct_pkg::VAL_W-1:0]  val_q;
  logic                               take_left;
  logic                               take_key;

  // Compare against the broadcast key
  assign eq_o = pos_i.occ && (code_q == cmd_i.key);
  assign gt_o = pos_i.occ && (code_q > cmd_i.key);

  // Insert: cells above the slot take their left neighbor
  assign take_left = cmd_i.ins && left_gt_i;
  assign take_key  = cmd_i.ins && !left_gt_i && (gt_o || pos_i.at_end);

  always_ff @(posedge clk_i) begin
    if (take_left) begin
      code_q <= left_code_i;
      val_q  <= left_val_i;
    end else if (take_key) begin
      code_q <= cmd_i.key;
      val_q  <= cmd_i.value;
    end else if (cmd_i.upd && eq_o) begin
      val_q  <= cmd_i.value;
    end
  end

  assign code_o = code_q;
  assign val_o  = val_q;

endmodule

// ===== rtl/plct_interp.sv =====
// Interpolation unit: serial multiply, radix-4 restoring divide, saturating add.
module plct_interp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [plct_pkg::CODE_W:0]   dk_i,
  input  logic signed [plct_pkg::VAL_W:0]    dv_i,
  input  logic [plct_pkg::CODE_W-1:0]        dc_i,
  input  logic signed [plct_pkg::VAL_W-1:0]  v1_i,
  output logic                               done_o,
  output logic signed [plct_pkg::VAL_W-1:0]  result_o
);

  localparam int CW     = plct_pkg::CODE_W;
  localparam int VW     = plct_pkg::VAL_W;
  localparam int HW     = VW / 2;
  localparam int PW     = CW + VW;
  localparam int STEPS  = PW / 2;
  localparam int SW     = PW + 2;
  localparam int CNT_W  = $clog2(STEPS);

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_MUL  = 4'b0010,
    U_DIV  = 4'b0100,
    U_SUM  = 4'b1000
  } unit_state_e;

  unit_state_e               state_q, state_d;
  logic [CNT_W-1:0]          cnt_q;
  logic [CW-1:0]             adk_q;
  logic [VW-1:0]             adv_q;
  logic                      neg_q;
  logic [CW-1:0]             dc_q;
  logic signed [VW-1:0]      v1_q;
  logic [PW-1:0]             prod_q;
  logic [CW-1:0]             rem_q;

  logic [CW:0]               dk_abs;
  logic [VW:0]               dv_abs;
  logic [HW-1:0]             mop;
  logic [CW+HW-1:0]          pp;
  logic [CW:0]               t1, t2;
  logic                      ge1, ge2;
  logic [CW-1:0]             r1, r2;
  logic signed [SW-1:0]      sq, sum;

  // Operand magnitudes
  assign dk_abs = dk_i[CW] ? -dk_i : dk_i;
  assign dv_abs = dv_i[VW] ? -dv_i : dv_i;

  // One 24x16 partial product per cycle
  assign mop = cnt_q[0] ? adv_q[VW-1:HW] : adv_q[HW-1:0];
  assign pp  = adk_q * mop;

  // Two quotient bits per cycle
  assign t1  = {rem_q, prod_q[PW-1]};
  assign ge1 = t1 >= {1'b0, dc_q};
  assign r1  = ge1 ? CW'(t1 - {1'b0, dc_q}) : t1[CW-1:0];
  assign t2  = {r1, prod_q[PW-2]};
  assign ge2 = t2 >= {1'b0, dc_q};
  assign r2  = ge2 ? CW'(t2 - {1'b0, dc_q}) : t2[CW-1:0];

  // Signed quotient plus base value, saturated
  assign sq  = neg_q ? -$signed({2'b00, prod_q}) : $signed({2'b00, prod_q});
  assign sum = SW'(v1_q) + sq;

  always_comb begin
    result_o = sum[VW-1:0];
    if (!(&sum[SW-1:VW-1]) && (|sum[SW-1:VW-1])) begin
      result_o = sum[SW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end
  end

  assign done_o = (state_q == U_SUM);

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      U_IDLE:  if (start_i) state_d = U_MUL;
      U_MUL:   if (cnt_q[0]) state_d = U_DIV;
      U_DIV:   if (cnt_q == CNT_W'(STEPS - 1)) state_d = U_SUM;
      U_SUM:   state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == U_IDLE || (state_q == U_MUL && cnt_q[0]) || state_q == U_SUM) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      U_IDLE: begin
        adk_q <= dk_abs[CW-1:0];
        adv_q <= dv_abs[VW-1:0];
        neg_q <= dk_i[CW] ^ dv_i[VW];
        dc_q  <= dc_i;
        v1_q  <= v1_i;
        rem_q <= '0;
      end
      U_MUL: begin
        prod_q <= cnt_q[0] ? prod_q + {pp, {HW{1'b0}}} : {{HW{1'b0}}, pp};
      end
      U_DIV: begin
        prod_q <= {prod_q[PW-3:0], ge1, ge2};
        rem_q  <= r2;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/piecewise_linear_calibration_table.sv =====
// Top level: calibration point table as a row of cells plus interpolation unit.
//
//   channel  | dir | handshake           | payload
//   in_i     | in  | valid/ready         | op, code, point_value
//   out_o    | out | valid/ready         | status, result_value
//   cfg      | in  | cfg_we_i, no stall  | cfg_wdata_i (capacity)
//
// Add, clear and unused op: accept, execute, result handoff.
// Lookup with exact match or too few points: those steps as well; interpolation
// adds a calculate phase for the serial multiply and 28 radix-4 divide steps.
// An item is taken while a previous result waits in the output register.
// Reset empties the table and sets capacity to 16; no clearing pass.
module piecewise_linear_calibration_table #(
  parameter int DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [plct_pkg::CAP_W-1:0]  cfg_wdata_i,
  plct_in_if.sink                     in_i,
  plct_out_if.source                  out_o
);

  localparam int CW   = plct_pkg::CODE_W;
  localparam int VW   = plct_pkg::VAL_W;
  localparam int NW   = $clog2(DEPTH + 1);
  localparam int CMPW = (NW > plct_pkg::CAP_W) ? NW : plct_pkg::CAP_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_CALC = 4'b0100,
    S_HOLD = 4'b1000
  } state_e;

  state_e                          state_q;
  logic [plct_pkg::CAP_W-1:0]      cap_q;
  logic [NW-1:0]                   fill_q;
  logic [plct_pkg::OP_W-1:0]       op_q;
  logic signed [CW-1:0]            key_q;
  logic signed [VW-1:0]            val_q;
  logic [plct_pkg::STAT_W-1:0]     pend_stat_q;
  logic signed [VW-1:0]            pend_res_q;
  logic                            out_valid_q;
  logic [plct_pkg::STAT_W-1:0]     out_stat_q;
  logic signed [VW-1:0]            out_res_q;

  plct_pkg::cell_cmd_t             cmd;
  plct_pkg::cell_pos_t             pos   [DEPTH];
  logic signed [CW-1:0]            code_a [DEPTH];
  logic signed [VW-1:0]            vals_a [DEPTH];
  logic [DEPTH-1:0]                gt_a, eq_a, le_a, occ_a, sel_a;

  logic [plct_pkg::CAP_W-1:0]      cap_eff;
  logic                            full;
  logic                            any_eq;
  logic signed [VW-1:0]            eq_val;
  logic signed [CW-1:0]            c1, c2;
  logic signed [VW-1:0]            v1, v2;
  logic signed [CW:0]              dk;
  logic signed [VW:0]              dv;
  logic [CW:0]                     dc;
  logic                            is_add, is_lookup, out_free;
  logic                            calc_start, calc_done;
  logic signed [VW-1:0]            calc_res;

  assign is_add    = (state_q == S_EXEC) && (op_q == plct_pkg::OP_ADD);
  assign is_lookup = (state_q == S_EXEC) && (op_q == plct_pkg::OP_LOOKUP);

  // Table full check against clamped capacity
  assign cap_eff = (cap_q < plct_pkg::CAP_W'(2)) ? plct_pkg::CAP_W'(2) : cap_q;
  assign full    = (fill_q >= NW'(DEPTH)) || (CMPW'(fill_q) >= CMPW'(cap_eff));

  // Broadcast command
  always_comb begin
    cmd.key   = key_q;
    cmd.value = val_q;
    cmd.upd   = is_add;
    cmd.ins   = is_add && !any_eq && !full;
  end

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ_a[i]      = NW'(i) < fill_q;
    assign pos[i].occ    = occ_a[i];
    assign pos[i].at_end = NW'(i) == fill_q;
    assign le_a[i]       = occ_a[i] && !gt_a[i];

    if (i == 0) begin : g_first
      plct_cell u_cell (
        .clk_i      (clk_i),
        .cmd_i      (cmd),
        .pos_i      (pos[i]),
        .left_code_i('0),
        .left_val_i ('0),
        .left_gt_i  (1'b0),
        .code_o     (code_a[i]),
        .val_o      (vals_a[i]),
        .gt_o       (gt_a[i]),
        .eq_o       (eq_a[i])
      );
    end else begin : g_next
      plct_cell u_cell (
        .clk_i      (clk_i),
        .cmd_i      (cmd),
        .pos_i      (pos[i]),
        .left_code_i(code_a[i-1]),
        .left_val_i (vals_a[i-1]),
        .left_gt_i  (gt_a[i-1]),
        .code_o     (code_a[i]),
        .val_o      (vals_a[i]),
        .gt_o       (gt_a[i]),
        .eq_o       (eq_a[i])
      );
    end

    // Lower point of the segment used for the lookup
    if (i < DEPTH - 1) begin : g_sel
      logic last_le, last_occ;
      assign last_le  = le_a[i] && !le_a[i+1];
      assign last_occ = occ_a[i] && !occ_a[i+1];
      if (i == 0) begin : g_sel0
        assign sel_a[i] = !le_a[i] || (last_le && !last_occ) ||
                          (le_a[i+1] && occ_a[i+1] && !(i + 2 < DEPTH && occ_a[(i+2)%DEPTH]));
      end else begin : g_seln
        assign sel_a[i] = (last_le && !last_occ) ||
                          (le_a[i+1] && occ_a[i+1] && !(i + 2 < DEPTH && occ_a[(i+2)%DEPTH]));
      end
    end else begin : g_sel_top
      assign sel_a[i] = 1'b0;
    end
  end

  // Match and segment selection across the row
  always_comb begin
    any_eq = |eq_a;
    eq_val = '0;
    c1 = '0;
    c2 = '0;
    v1 = '0;
    v2 = '0;
    for (int i = 0; i < DEPTH; i++) begin
      eq_val = eq_val | (eq_a[i] ? vals_a[i] : '0);
      c1     = c1 | (sel_a[i] ? code_a[i] : '0);
      v1     = v1 | (sel_a[i] ? vals_a[i] : '0);
      if (i < DEPTH - 1) begin
        c2 = c2 | (sel_a[i] ? code_a[(i+1)%DEPTH] : '0);
        v2 = v2 | (sel_a[i] ? vals_a[(i+1)%DEPTH] : '0);
      end
    end
  end

  assign dk = (CW+1)'(key_q) - (CW+1)'(c1);
  assign dv = (VW+1)'(v2) - (VW+1)'(v1);
  assign dc = (CW+1)'(c2) - (CW+1)'(c1);

  assign calc_start = is_lookup && !(fill_q < NW'(2)) && !any_eq;

  plct_interp u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (calc_start),
    .dk_i    (dk),
    .dv_i    (dv),
    .dc_i    (dc[CW-1:0]),
    .v1_i    (v1),
    .done_o  (calc_done),
    .result_o(calc_res)
  );

  assign out_free = !out_valid_q || out_o.ready;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= plct_pkg::CAP_RESET;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      // Output valid: load a new item or drop the one taken
      if (state_q == S_HOLD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (cmd.ins) fill_q <= fill_q + 1'b1;
          if (op_q == plct_pkg::OP_CLEAR) fill_q <= '0;
          state_q <= calc_start ? S_CALC : S_HOLD;
        end
        S_CALC: begin
          if (calc_done) state_q <= S_HOLD;
        end
        S_HOLD: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Item capture, pending result and output register
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_i.valid) begin
      op_q  <= in_i.op;
      key_q <= in_i.code;
      val_q <= in_i.point_value;
    end
    if (state_q == S_EXEC) begin
      pend_stat_q <= plct_pkg::STAT_OK;
      pend_res_q  <= '0;
      if (is_add && !any_eq && full) begin
        pend_stat_q <= plct_pkg::STAT_FULL;
      end
      if (is_lookup) begin
        if (fill_q < NW'(2)) begin
          pend_stat_q <= plct_pkg::STAT_FEW;
        end else if (any_eq) begin
          pend_res_q <= eq_val;
        end
      end
    end
    if (state_q == S_CALC && calc_done) begin
      pend_res_q <= calc_res;
    end
    if (state_q == S_HOLD && out_free) begin
      out_stat_q <= pend_stat_q;
      out_res_q  <= pend_res_q;
    end
  end

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_stat_q;
  assign out_o.result_value = out_res_q;

endmodule
